### hdl/lcr_pkg.sv
// Shared constants, types and FSM encoding for the LFU cache.
// No dependencies; used by every module of the block.
`default_nettype none
package lcr_pkg;
    localparam int CAPACITY    = 16;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int RANK_W      = IDX_W;
    localparam int OCC_W       = $clog2(CAPACITY + 1);
    localparam int COUNT_WIDTH = 16;
    localparam int CAP_W       = 5;
    localparam int DATA_W      = 32;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic                   OP_GET    = 1'b0;
    localparam logic                   OP_PUT    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic             start;
        logic             scan_en;
        logic [IDX_W-1:0] scan_idx;
        logic             act;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cap_zero;
        logic out_stall;
    } status_t;
endpackage
`default_nettype wire

### hdl/lcr_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on lcr_pkg for data widths.
`default_nettype none
interface lcr_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic signed [lcr_pkg::DATA_W-1:0] key;
    logic signed [lcr_pkg::DATA_W-1:0] value;
    modport source (output valid, op, key, value, input ready);
    modport sink   (input valid, op, key, value, output ready);
endinterface

interface lcr_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic signed [lcr_pkg::DATA_W-1:0] read_value;
    logic                        evicted;
    logic signed [lcr_pkg::DATA_W-1:0] evicted_key;
    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface
`default_nettype wire

### hdl/lcr_ctrl.sv
// Sequencer for the LFU cache: accept, scan entries, apply and emit.
// Depends on lcr_pkg.
`default_nettype none
module lcr_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_fire,
    input  wire lcr_pkg::status_t status,
    output lcr_pkg::cmd_t         cmd,
    output logic                  req_ready
);
    lcr_pkg::state_t state_reg, state_next;
    logic [lcr_pkg::IDX_W-1:0] idx_reg, idx_next;

    // state and scan counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcr_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            lcr_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (req_fire)
                    state_next = lcr_pkg::ST_SCAN;
            end
            lcr_pkg::ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (status.cap_zero || idx_reg == lcr_pkg::IDX_W'(lcr_pkg::CAPACITY - 1))
                    state_next = lcr_pkg::ST_ACT;
            end
            lcr_pkg::ST_ACT:
            begin
                if (!status.out_stall)
                    state_next = lcr_pkg::ST_IDLE;
            end
            default: state_next = lcr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        cmd.scan_idx = idx_reg;
        req_ready    = 1'b0;
        unique case (state_reg)
            lcr_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.start = req_fire;
            end
            lcr_pkg::ST_SCAN: cmd.scan_en = !status.cap_zero;
            lcr_pkg::ST_ACT:  cmd.act = !status.out_stall;
            default:          req_ready = 1'b0;
        endcase
    end
endmodule
`default_nettype wire

### hdl/lcr_dp.sv
// Entry storage, scan comparators and update logic of the LFU cache.
// Depends on lcr_pkg.
`default_nettype none
module lcr_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lcr_pkg::cmd_t                     cmd,
    output lcr_pkg::status_t                       status,
    input  wire logic                              cfg_we,
    input  wire logic [lcr_pkg::CAP_W-1:0]         cfg_wdata,
    input  wire logic                              in_op,
    input  wire logic [lcr_pkg::DATA_W-1:0]        in_key,
    input  wire logic [lcr_pkg::DATA_W-1:0]        in_value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   out_hit,
    output logic [lcr_pkg::DATA_W-1:0]             out_read_value,
    output logic                                   out_evicted,
    output logic [lcr_pkg::DATA_W-1:0]             out_evicted_key
);
    localparam int N  = lcr_pkg::CAPACITY;
    localparam int IW = lcr_pkg::IDX_W;
    localparam int RW = lcr_pkg::RANK_W;
    localparam int CW = lcr_pkg::COUNT_WIDTH;
    localparam int DW = lcr_pkg::DATA_W;

    logic [N-1:0]   valid_reg, valid_next;
    logic [DW-1:0]  key_reg  [N];
    logic [DW-1:0]  val_reg  [N];
    logic [CW-1:0]  cnt_reg  [N];
    logic [RW-1:0]  rank_reg [N];
    logic [lcr_pkg::OCC_W-1:0] occ_reg;
    logic [lcr_pkg::CAP_W-1:0] cap_cfg_reg;

    // latched item and scan results
    logic           op_reg, off_reg;
    logic [DW-1:0]  ikey_reg, ival_reg;
    logic           found_reg, vict_reg, free_reg;
    logic [IW-1:0]  fidx_reg, vidx_reg, free_idx_reg;
    logic [DW-1:0]  fval_reg, vkey_reg;
    logic [RW-1:0]  frank_reg, vrank_reg;
    logic [CW-1:0]  vcnt_reg;

    logic           out_valid_reg, hit_reg, ev_reg;
    logic [DW-1:0]  rd_reg, evk_reg;

    logic [lcr_pkg::CAP_W-1:0] cap_eff;
    logic           do_hit, do_evict, do_insert;
    logic [IW-1:0]  slot;
    logic           e_val;
    logic [CW-1:0]  e_cnt;
    logic [RW-1:0]  e_rank;

    assign cap_eff = (cap_cfg_reg > lcr_pkg::CAP_W'(N)) ? lcr_pkg::CAP_W'(N) : cap_cfg_reg;
    assign status.cap_zero  = off_reg;
    assign status.out_stall = out_valid_reg && !out_ready;

    assign e_val  = valid_reg[cmd.scan_idx];
    assign e_cnt  = cnt_reg[cmd.scan_idx];
    assign e_rank = rank_reg[cmd.scan_idx];

    assign do_hit    = cmd.act && !off_reg && found_reg;
    assign do_insert = cmd.act && !off_reg && !found_reg && op_reg == lcr_pkg::OP_PUT;
    assign do_evict  = do_insert && vict_reg &&
                       lcr_pkg::CAP_W'(occ_reg) >= cap_eff;
    assign slot      = free_reg ? free_idx_reg : vidx_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_cfg_reg <= lcr_pkg::CAP_W'(N);
        else if (cfg_we)
            cap_cfg_reg <= cfg_wdata;
    end

    // latch the item, then scan one entry a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= 1'b0;
            found_reg <= 1'b0;
            vict_reg  <= 1'b0;
            free_reg  <= 1'b0;
        end
        else if (cmd.start)
        begin
            off_reg   <= (cap_eff == '0);
            found_reg <= 1'b0;
            vict_reg  <= 1'b0;
            free_reg  <= 1'b0;
        end
        else if (cmd.scan_en)
        begin
            if (e_val && key_reg[cmd.scan_idx] == ikey_reg)
                found_reg <= 1'b1;
            if (e_val && (!vict_reg || e_cnt < vcnt_reg ||
                          (e_cnt == vcnt_reg && e_rank > vrank_reg)))
                vict_reg <= 1'b1;
            if (!e_val)
                free_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg   <= in_op;
            ikey_reg <= in_key;
            ival_reg <= in_value;
        end
        else if (cmd.scan_en)
        begin
            if (e_val && key_reg[cmd.scan_idx] == ikey_reg)
            begin
                fidx_reg  <= cmd.scan_idx;
                fval_reg  <= val_reg[cmd.scan_idx];
                frank_reg <= e_rank;
            end
            if (e_val && (!vict_reg || e_cnt < vcnt_reg ||
                          (e_cnt == vcnt_reg && e_rank > vrank_reg)))
            begin
                vidx_reg  <= cmd.scan_idx;
                vkey_reg  <= key_reg[cmd.scan_idx];
                vcnt_reg  <= e_cnt;
                vrank_reg <= e_rank;
            end
            if (!e_val && !free_reg)
                free_idx_reg <= cmd.scan_idx;
        end
    end

    // drop the victim, then mark the inserted slot
    always_comb
    begin
        valid_next = valid_reg;
        if (do_evict)
            valid_next[vidx_reg] = 1'b0;
        if (do_insert)
            valid_next[slot] = 1'b1;
    end

    // apply touch, evict and insert to every entry in parallel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (do_insert && !do_evict)
                occ_reg <= occ_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < N; j++)
        begin
            if (do_hit && valid_reg[j])
            begin
                if (IW'(j) == fidx_reg)
                begin
                    rank_reg[j] <= '0;
                    if (cnt_reg[j] != lcr_pkg::COUNT_MAX)
                        cnt_reg[j] <= cnt_reg[j] + 1'b1;
                    if (op_reg == lcr_pkg::OP_PUT)
                        val_reg[j] <= ival_reg;
                end
                else if (rank_reg[j] < frank_reg)
                    rank_reg[j] <= rank_reg[j] + 1'b1;
            end
            else if (do_insert)
            begin
                if (IW'(j) == slot)
                begin
                    key_reg[j]  <= ikey_reg;
                    val_reg[j]  <= ival_reg;
                    cnt_reg[j]  <= CW'(1);
                    rank_reg[j] <= '0;
                end
                else if (valid_reg[j] && !(do_evict && IW'(j) == vidx_reg))
                begin
                    if (do_evict && rank_reg[j] > vrank_reg)
                        rank_reg[j] <= rank_reg[j];
                    else
                        rank_reg[j] <= rank_reg[j] + 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.act)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.act)
        begin
            hit_reg <= !off_reg && found_reg;
            rd_reg  <= (!off_reg && found_reg && op_reg == lcr_pkg::OP_GET) ? fval_reg : '1;
            ev_reg  <= do_evict;
            evk_reg <= do_evict ? vkey_reg : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_hit         = hit_reg;
    assign out_read_value  = rd_reg;
    assign out_evicted     = ev_reg;
    assign out_evicted_key = evk_reg;
endmodule
`default_nettype wire

### hdl/lfu_cache_replacement.sv
// LFU cache with LRU tie break, 16 fully associative entries.
// Each item is accepted in IDLE, scanned over all 16 entries in SCAN, applied in ACT
// (held while the response stalls) with the result registered; one item in flight, the scan
// of all entries sets the rate. Capacity zero skips the scan. Reset clears all valid bits,
// occupancy, and sets capacity to 16; no clearing pass is needed.
`default_nettype none
module lfu_cache_replacement (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [lcr_pkg::CAP_W-1:0] cfg_wdata,
    lcr_req_if.sink                        req,
    lcr_rsp_if.source                      rsp
);
    lcr_pkg::cmd_t    cmd;
    lcr_pkg::status_t status;
    logic             req_ready;

    assign req.ready = req_ready;

    lcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_fire  (req.valid && req_ready),
        .status    (status),
        .cmd       (cmd),
        .req_ready (req_ready)
    );

    lcr_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_op           (req.op),
        .in_key          (req.key),
        .in_value        (req.value),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .out_hit         (rsp.hit),
        .out_read_value  (rsp.read_value),
        .out_evicted     (rsp.evicted),
        .out_evicted_key (rsp.evicted_key)
    );

    // an eviction never coincides with a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.evicted |-> !rsp.hit)
        else $error("eviction reported on a hit");

    // no eviction means a zero evicted key
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.evicted |-> rsp.evicted_key == '0)
        else $error("evicted key set without eviction");

    // one item in flight: ready drops after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("second item accepted during scan");
endmodule
`default_nettype wire

### tb/sv/tb_lcr_channels.sv
// Testbench-side notes: the request and response channels are the RTL's own
// lcr_req_if / lcr_rsp_if (hdl/lcr_if.sv); this file holds the shared tb types.
// Depends on lcr_pkg.
package tb_lcr_types;
    import lcr_pkg::*;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
        logic signed [DATA_W-1:0] evicted_key;
    } lookup_result_t;
endpackage

### tb/sv/tb_lfu_cache_replacement.sv
// Self-checking bench for the LFU cache: a behavioral cache model predicts each
// lookup/insert result, compared field by field against the response channel.
// Depends on lcr_pkg, lcr_if.sv, tb_lcr_types and lfu_cache_replacement.
module tb_lfu_cache_replacement;
    timeunit 1ns;
    timeprecision 1ps;
    import lcr_pkg::*;
    import tb_lcr_types::*;

    localparam int DRAIN_CYCLES = 40;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CAP_W-1:0]     cfg_wdata = '0;

    lcr_req_if req ();
    lcr_rsp_if rsp ();

    lfu_cache_replacement DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    // clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // cache shadow state
    logic [CAP_W-1:0]        shadow_cap;
    logic                    slot_valid [CAPACITY];
    logic [DATA_W-1:0]       slot_key   [CAPACITY];
    logic [DATA_W-1:0]       slot_value [CAPACITY];
    logic [COUNT_WIDTH-1:0]  slot_count [CAPACITY];
    int unsigned             slot_rank  [CAPACITY];
    int unsigned             slot_used;

    lookup_result_t pending_results [$];
    int unsigned    error_count = 0;
    logic [DATA_W-1:0] key_pool [8];

    function automatic int find_slot(logic [DATA_W-1:0] k);
        for (int i = 0; i < CAPACITY; i++)
            if (slot_valid[i] && slot_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void bump_slot(int e);
        int unsigned r;
        r = slot_rank[e];
        for (int i = 0; i < CAPACITY; i++)
            if (slot_valid[i] && slot_rank[i] < r)
                slot_rank[i]++;
        slot_rank[e] = 0;
        if (slot_count[e] != COUNT_MAX)
            slot_count[e]++;
    endfunction

    // compute one lookup/insert result and advance the shadow cache
    function automatic lookup_result_t cache_predict(logic op, logic [DATA_W-1:0] k,
                                                     logic [DATA_W-1:0] v);
        lookup_result_t res;
        int unsigned    cap;
        int             e;
        int             victim;
        int             freeslot;
        int unsigned    r;
        res = '{hit: 1'b0, read_value: -1, evicted: 1'b0, evicted_key: '0};
        cap = (shadow_cap > CAPACITY) ? CAPACITY : shadow_cap;
        if (cap == 0)
            return res;
        e = find_slot(k);
        if (e >= 0)
        begin
            res.hit = 1'b1;
            if (op == OP_GET)
                res.read_value = slot_value[e];
            else
                slot_value[e] = v;
            bump_slot(e);
            return res;
        end
        if (op == OP_GET)
            return res;
        // evict lowest count, oldest on ties
        if (slot_used >= cap)
        begin
            victim = -1;
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (!slot_valid[i])
                    continue;
                if (victim < 0 || slot_count[i] < slot_count[victim] ||
                    (slot_count[i] == slot_count[victim] &&
                     slot_rank[i] > slot_rank[victim]))
                    victim = i;
            end
            if (victim >= 0)
            begin
                r = slot_rank[victim];
                for (int i = 0; i < CAPACITY; i++)
                    if (slot_valid[i] && slot_rank[i] > r)
                        slot_rank[i]--;
                slot_valid[victim] = 1'b0;
                if (slot_used > 0)
                    slot_used--;
                res.evicted = 1'b1;
                res.evicted_key = slot_key[victim];
            end
        end
        freeslot = -1;
        for (int i = 0; i < CAPACITY; i++)
            if (!slot_valid[i] && freeslot < 0)
                freeslot = i;
        if (freeslot >= 0)
        begin
            for (int i = 0; i < CAPACITY; i++)
                if (slot_valid[i])
                    slot_rank[i]++;
            slot_valid[freeslot] = 1'b1;
            slot_key[freeslot]   = k;
            slot_value[freeslot] = v;
            slot_count[freeslot] = 1;
            slot_rank[freeslot]  = 0;
            slot_used++;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        error_count++;
        $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    // response checker with its own stall pattern
    logic [7:0] stall_pattern;
    logic [7:0] stall_next;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready     <= 1'b0;
            stall_pattern <= 8'b1011_0111;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result", rsp.read_value, '0);
                end
                else
                begin
                    lookup_result_t want;
                    want = pending_results.pop_front();
                    if (rsp.hit !== want.hit)
                        report_mismatch("hit", rsp.hit, want.hit);
                    if (rsp.read_value !== want.read_value)
                        report_mismatch("read_value", rsp.read_value, want.read_value);
                    if (rsp.evicted !== want.evicted)
                        report_mismatch("evicted", rsp.evicted, want.evicted);
                    if (rsp.evicted_key !== want.evicted_key)
                        report_mismatch("evicted_key", rsp.evicted_key, want.evicted_key);
                end
            end
            // rotate the pattern, reseed it now and then, long runs of ready
            stall_next = {stall_pattern[6:0], stall_pattern[7]};
            if ($urandom_range(0, 63) == 0)
                stall_next = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
            stall_pattern <= stall_next;
            rsp.ready <= stall_pattern[0];
        end
    end

    initial
    begin
        req.valid = 1'b0;
        req.op    = OP_GET;
        req.key   = '0;
        req.value = '0;
    end

    int burst_left = 0;

    // send one item; bursts of random length separated by random gaps
    task automatic send_item(logic op, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 30);
            if (gap != 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.valid <= 1'b1;
        req.op    <= op;
        req.key   <= k;
        req.value <= v;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_results.push_back(cache_predict(op, k, v));
    endtask

    // wait for all results, then let the block settle before a register write
    task automatic drain;
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] c);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_cap = c;
    endtask

    function automatic logic [DATA_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 8)
            return key_pool[$urandom_range(0, 7)] + $urandom_range(0, 5);
        return $urandom;
    endfunction

    task automatic test_directed_extremes;
        send_item(OP_GET, 32'h8000_0000, 32'h0);
        send_item(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_PUT, 32'h0, 32'h0);
        send_item(OP_GET, 32'h8000_0000, 32'h1234_5678);
        send_item(OP_GET, 32'h7FFF_FFFF, 32'h0);
        send_item(OP_PUT, 32'hFFFF_FFFF, 32'h5555_AAAA);
        send_item(OP_GET, 32'hFFFF_FFFF, 32'h0);
        send_item(OP_GET, 32'h1, 32'h0);
    endtask

    // small capacity: eviction by count and by recency tie
    task automatic test_eviction_order;
        write_capacity(5'd2);
        send_item(OP_PUT, 32'd10, 32'd100);
        send_item(OP_PUT, 32'd11, 32'd110);
        send_item(OP_PUT, 32'd12, 32'd120);
        send_item(OP_GET, 32'd12, 32'd0);
        send_item(OP_PUT, 32'd13, 32'd130);
        send_item(OP_GET, 32'd10, 32'd0);
        // raised above occupancy: new puts fill free slots; then lowered below it: each new put evicts exactly one
        write_capacity(5'd16);
        for (int i = 0; i < 6; i++)
            send_item(OP_PUT, 32'd20 + i, 32'd200 + i);
        write_capacity(5'd1);
        send_item(OP_PUT, 32'd99, 32'd999);
        send_item(OP_PUT, 32'd98, 32'd998);
    endtask

    task automatic test_disabled_and_oversize;
        write_capacity(5'd0);
        send_item(OP_PUT, 32'd55, 32'd1);
        send_item(OP_GET, 32'd98, 32'd0);
        write_capacity(5'd31);
        send_item(OP_GET, 32'd98, 32'd0);
        send_item(OP_PUT, 32'd56, 32'd2);
    endtask

    // drive one entry toward a high count; saturation itself is modeled
    task automatic test_count_build;
        write_capacity(5'd16);
        for (int i = 0; i < 40; i++)
            send_item(OP_GET, 32'd98, 32'd0);
    endtask

    task automatic test_random_traffic;
        logic [CAP_W-1:0] caps [6];
        caps = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd8, 5'd31};
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFF8;
        for (int phase = 0; phase < 6; phase++)
        begin
            write_capacity(caps[phase]);
            for (int n = 0; n < 330; n++)
                send_item(logic'($urandom_range(0, 1)), pick_key(), $urandom);
        end
    endtask

    initial
    begin
        shadow_cap = 5'd16;
        slot_used  = 0;
        foreach (slot_valid[i])
        begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_count[i] = '0;
            slot_rank[i]  = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_eviction_order();
        test_disabled_and_oversize();
        test_count_build();
        test_random_traffic();
        drain();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hard stop: ~2100 items x (scan + stalls + gaps) with wide margin
    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
